// File: src/pcvs_pkg.sv
// ----------------------------------------------------------------------------
// pcvs_pkg
// Types and constants shared by the per-class value statistics block.
// ----------------------------------------------------------------------------
package pcvs_pkg;

  // field widths of one transaction and of the statistics
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CLASS_W = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 24;
  localparam int unsigned SUM_W   = 56;
  localparam int unsigned SQ_W    = 64;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // saturation limits
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [SQ_W-1:0]    SQ_MAX    = {SQ_W{1'b1}};

  // statistics of one class
  typedef struct packed {
    logic [COUNT_W-1:0]        sample_count;
    logic signed [VALUE_W-1:0] min_value;
    logic signed [VALUE_W-1:0] max_value;
    logic signed [SUM_W-1:0]   value_sum;
    logic [SQ_W-1:0]           square_sum;
  } stats_t;

  // one table entry as held in memory
  typedef struct packed {
    logic   valid;
    stats_t stats;
  } entry_t;

endpackage

// File: src/pcvs_req_if.sv
// ----------------------------------------------------------------------------
// pcvs_req_if
// Input channel: update, query or clear transactions.
// ----------------------------------------------------------------------------
interface pcvs_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         class_id;
  logic signed [31:0] value;

  modport source (output valid, kind, class_id, value, input ready);
  modport sink   (input valid, kind, class_id, value, output ready);
endinterface

// File: src/pcvs_rsp_if.sv
// ----------------------------------------------------------------------------
// pcvs_rsp_if
// Output channel: statistics of one class, returned for each query.
// ----------------------------------------------------------------------------
interface pcvs_rsp_if;
  logic               valid;
  logic               ready;
  logic [23:0]        sample_count;
  logic signed [31:0] min_value;
  logic signed [31:0] max_value;
  logic signed [55:0] value_sum;
  logic [63:0]        square_sum;

  modport source (output valid, sample_count, min_value, max_value, value_sum,
                  square_sum, input ready);
  modport sink   (input valid, sample_count, min_value, max_value, value_sum,
                  square_sum, output ready);
endinterface

// File: src/pcvs_merge.sv
// ----------------------------------------------------------------------------
// pcvs_merge
// Folds one sample and its square into a table entry, with saturation.
// ----------------------------------------------------------------------------
module pcvs_merge (
  input  pcvs_pkg::entry_t        entry_i,
  input  logic signed [31:0]      sample_i,
  input  logic [63:0]             square_i,
  output pcvs_pkg::entry_t        entry_o
);
  import pcvs_pkg::*;

  logic [SUM_W:0] sum_wide;
  logic [SQ_W:0]  sq_wide;

  // wide sums, one guard bit each
  assign sum_wide = {entry_i.stats.value_sum[SUM_W-1], entry_i.stats.value_sum}
                  + (SUM_W+1)'(sample_i);
  assign sq_wide  = {1'b0, entry_i.stats.square_sum} + {1'b0, square_i};

  always_comb begin
    entry_o = entry_i;
    if (!entry_i.valid) begin
      // first sample of an empty class
      entry_o.valid              = 1'b1;
      entry_o.stats.sample_count = COUNT_W'(1);
      entry_o.stats.min_value    = sample_i;
      entry_o.stats.max_value    = sample_i;
      entry_o.stats.value_sum    = SUM_W'(sample_i);
      entry_o.stats.square_sum   = square_i;
    end else begin
      // saturating count
      if (entry_i.stats.sample_count != COUNT_MAX) begin
        entry_o.stats.sample_count = entry_i.stats.sample_count + COUNT_W'(1);
      end
      // extremes
      if (sample_i < entry_i.stats.min_value) begin
        entry_o.stats.min_value = sample_i;
      end
      if (sample_i > entry_i.stats.max_value) begin
        entry_o.stats.max_value = sample_i;
      end
      // signed sum, clamped at both ends
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
        entry_o.stats.value_sum = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
        entry_o.stats.value_sum = sum_wide[SUM_W-1:0];
      end
      // square sum, clamped at the top
      if (sq_wide[SQ_W]) begin
        entry_o.stats.square_sum = SQ_MAX;
      end else begin
        entry_o.stats.square_sum = sq_wide[SQ_W-1:0];
      end
    end
  end

endmodule

// File: src/per_class_value_statistics.sv
// ----------------------------------------------------------------------------
// per_class_value_statistics
// Per-class table of count, minimum, maximum, sum and sum of squares.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries update, query and clear transactions (valid/ready). An
//   update adds a signed Q16.16 sample to its class; a query returns the
//   class statistics on rsp_o; a clear empties the whole table.
//   The table sits in one synchronous memory, one entry per class. On
//   accept the sample is squared and the entry is read into a register;
//   in the merge stage an update is merged and written back, and a query
//   loads the output register, from which the result appears on rsp_o.
//   req_i is not ready while a transaction is in the merge stage.
//   A clear, and reset, start a sweep that drops the valid bit of every
//   entry; req_i is not ready during the sweep.
//   When rsp_o stalls, updates and clears are still accepted; the next
//   query waits in the merge stage until the output register frees up,
//   and req_i is not ready while it waits.
// ----------------------------------------------------------------------------
module per_class_value_statistics #(
  parameter int unsigned CLASS_COUNT = 256,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcvs_req_if.sink   req_i,
  pcvs_rsp_if.source rsp_o
);
  import pcvs_pkg::*;

  localparam int unsigned AW = $clog2(CLASS_COUNT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(CLASS_COUNT - 1);

  typedef enum logic [2:0] {
    ST_SWEEP = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0]  sweep_q, sweep_d;
  logic           req_fire;
  logic [AW+7:0]  class_ext;
  logic           in_range_d;

  logic signed [VALUE_BITS-1:0] raw_value;
  logic signed [VALUE_W-1:0]    sample_d;
  logic signed [2*VALUE_W-1:0]  product;

  // captured transaction
  logic [KIND_W-1:0]         kind_q;
  logic [AW-1:0]             addr_q;
  logic                      in_range_q;
  logic signed [VALUE_W-1:0] sample_q;
  logic [SQ_W-1:0]           square_q;

  // table memory
  entry_t        mem_q [CLASS_COUNT];
  entry_t        rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  entry_t        merged;

  // output register
  logic   out_valid_q, out_valid_d;
  logic   out_load;
  stats_t out_q;

  assign req_fire  = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  // class decode and range check
  assign class_ext  = {{AW{1'b0}}, req_i.class_id};
  assign in_range_d = class_ext < (AW+8)'(CLASS_COUNT);

  // sample from the low bits of the value field, then its square
  assign raw_value = req_i.value[VALUE_BITS-1:0];
  assign sample_d  = VALUE_W'(raw_value);
  assign product   = sample_d * sample_d;

  // capture on accept
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      kind_q     <= req_i.kind;
      addr_q     <= class_ext[AW-1:0];
      in_range_q <= in_range_d;
      sample_q   <= sample_d;
      square_q   <= SQ_W'(product);
    end
  end

  // merge of the read entry
  pcvs_merge u_merge (
    .entry_i  (rd_q),
    .sample_i (sample_q),
    .square_i (square_q),
    .entry_o  (merged)
  );

  // memory write port: sweep or update write-back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = merged;
    if (state_q == ST_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_q;
      mem_wdata = '0;
    end else if (state_q == ST_EXEC && kind_q == KIND_UPDATE && in_range_q) begin
      mem_we = 1'b1;
    end
  end

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (req_fire) begin
      rd_q <= mem_q[class_ext[AW-1:0]];
    end
  end

  // output register load for a query
  assign out_load = (state_q == ST_EXEC) && (kind_q == KIND_QUERY)
                  && (!out_valid_q || rsp_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= (in_range_q && rd_q.valid) ? rd_q.stats : '0;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.sample_count = out_q.sample_count;
  assign rsp_o.min_value    = out_q.min_value;
  assign rsp_o.max_value    = out_q.max_value;
  assign rsp_o.value_sum    = out_q.value_sum;
  assign rsp_o.square_sum   = out_q.square_sum;

  // sequencer
  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    case (state_q)
      ST_SWEEP: begin
        if (sweep_q == LAST_ADDR) begin
          state_d = ST_IDLE;
          sweep_d = '0;
        end else begin
          sweep_d = sweep_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (req_fire) begin
          if (req_i.kind == KIND_CLEAR) begin
            state_d = ST_SWEEP;
            sweep_d = '0;
          end else if (req_i.kind == KIND_UPDATE || req_i.kind == KIND_QUERY) begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        if (kind_q != KIND_QUERY || out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_SWEEP;
        sweep_d = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a new result only comes out of the merge stage
  a_rsp_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(state_q == ST_EXEC))
    else $error("result appeared without a query in the merge stage");

  // an accepted clear starts a sweep
  a_clear_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_i.kind == KIND_CLEAR) |=> (state_q == ST_SWEEP && sweep_q == '0))
    else $error("clear did not start a sweep from the first entry");

  // the sweep ends after the last entry
  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && sweep_q == LAST_ADDR) |=> (state_q == ST_IDLE))
    else $error("sweep did not end after the last entry");

  // no table write while waiting for a transaction
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_we)
    else $error("table written while idle");

endmodule

// File: tb/tb_per_class_value_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_class_value_statistics
// Self-checking bench for the per-class value statistics table. Update,
// query and clear transactions go in over the request channel. A shadow
// table in the bench tracks every accepted transaction, and each query
// result is compared field by field with the oldest expected entry.
// ----------------------------------------------------------------------------
module tb_per_class_value_statistics;
  import pcvs_pkg::*;

  localparam int unsigned NUM_CLASSES  = 256;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam longint SUM_HI = longint'($signed(SUM_MAX));
  localparam longint SUM_LO = longint'($signed(SUM_MIN));

  localparam logic signed [VALUE_W-1:0] VALUE_TOP    = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_BOTTOM = {1'b1, {(VALUE_W-1){1'b0}}};

  logic        clk;
  logic        rst_n;
  bit          src_idle_on;
  bit          snk_idle_on;
  bit          hold_rsp;
  int unsigned error_count;
  int unsigned quiet_cycles;

  pcvs_req_if req ();
  pcvs_rsp_if rsp ();

  per_class_value_statistics #(
    .CLASS_COUNT(NUM_CLASSES),
    .VALUE_BITS (VALUE_W)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp)
  );

  // shadow copy of the statistics table
  bit                        stat_valid [NUM_CLASSES];
  logic [COUNT_W-1:0]        stat_count [NUM_CLASSES];
  logic signed [VALUE_W-1:0] stat_min   [NUM_CLASSES];
  logic signed [VALUE_W-1:0] stat_max   [NUM_CLASSES];
  longint                    stat_sum   [NUM_CLASSES];
  logic [SQ_W-1:0]           stat_sq    [NUM_CLASSES];

  // query results still owed by the block, oldest first
  stats_t pending_stats [$];

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // fold one sample into the shadow entry of its class
  function automatic void accumulate_sample(int unsigned cls, logic signed [VALUE_W-1:0] v);
    longint          s;
    logic [SQ_W-1:0] sq;
    sq = SQ_W'(longint'(v) * longint'(v));
    if (!stat_valid[cls]) begin
      stat_valid[cls] = 1'b1;
      stat_count[cls] = COUNT_W'(1);
      stat_min[cls]   = v;
      stat_max[cls]   = v;
      stat_sum[cls]   = longint'(v);
      stat_sq[cls]    = sq;
    end else begin
      if (stat_count[cls] != COUNT_MAX) stat_count[cls]++;
      if (v < stat_min[cls]) stat_min[cls] = v;
      if (v > stat_max[cls]) stat_max[cls] = v;
      s = stat_sum[cls] + longint'(v);
      if (s > SUM_HI) s = SUM_HI;
      if (s < SUM_LO) s = SUM_LO;
      stat_sum[cls] = s;
      if (stat_sq[cls] > SQ_MAX - sq) stat_sq[cls] = SQ_MAX;
      else stat_sq[cls] = stat_sq[cls] + sq;
    end
  endfunction

  // apply one accepted transaction to the shadow table
  function automatic void track_transaction(logic [KIND_W-1:0] kind,
                                            logic [CLASS_W-1:0] cls,
                                            logic signed [VALUE_W-1:0] value);
    stats_t st;
    case (kind)
      KIND_UPDATE: begin
        if (int'(cls) < NUM_CLASSES) accumulate_sample(32'(cls), value);
      end
      KIND_QUERY: begin
        st = '0;
        if (int'(cls) < NUM_CLASSES && stat_valid[cls]) begin
          st.sample_count = stat_count[cls];
          st.min_value    = stat_min[cls];
          st.max_value    = stat_max[cls];
          st.value_sum    = SUM_W'(stat_sum[cls]);
          st.square_sum   = stat_sq[cls];
        end
        pending_stats.push_back(st);
      end
      KIND_CLEAR: begin
        foreach (stat_valid[i]) stat_valid[i] = 1'b0;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    error_count++;
  endtask

  // track requests and check responses
  always @(posedge clk) begin
    stats_t want;
    if (rst_n) begin
      if (req.valid && req.ready) track_transaction(req.kind, req.class_id, req.value);
      if (rsp.valid && rsp.ready) begin
        if (pending_stats.size() == 0) begin
          report_mismatch("result with no query pending", '0, '0);
        end else begin
          want = pending_stats.pop_front();
          if (rsp.sample_count !== want.sample_count)
            report_mismatch("sample_count", want.sample_count, rsp.sample_count);
          if (rsp.min_value !== want.min_value)
            report_mismatch("min_value", want.min_value, rsp.min_value);
          if (rsp.max_value !== want.max_value)
            report_mismatch("max_value", want.max_value, rsp.max_value);
          if (rsp.value_sum !== want.value_sum)
            report_mismatch("value_sum", want.value_sum, rsp.value_sum);
          if (rsp.square_sum !== want.square_sum)
            report_mismatch("square_sum", want.square_sum, rsp.square_sum);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // response side: long hold when asked, else random stall bursts
  always @(posedge clk) begin
    if (hold_rsp) begin
      rsp.ready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_rsp = 1'b0;
      rsp.ready <= 1'b1;
    end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
      rsp.ready <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      rsp.ready <= 1'b1;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // offer one transaction and wait until it is accepted
  task automatic send_item(input logic [KIND_W-1:0] kind,
                           input logic [CLASS_W-1:0] cls,
                           input logic signed [VALUE_W-1:0] value);
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.kind     <= kind;
    req.class_id <= cls;
    req.value    <= value;
    do @(posedge clk); while (!req.ready);
  endtask

  // one random transaction, biased to a few classes so entries build up
  task automatic send_random_item(output bit ignored);
    logic [KIND_W-1:0]         kind;
    logic [CLASS_W-1:0]        cls;
    logic signed [VALUE_W-1:0] value;
    int unsigned               pick;
    pick = $urandom_range(0, 99);
    if (pick < 60)      kind = KIND_UPDATE;
    else if (pick < 97) kind = KIND_QUERY;
    else if (pick < 99) kind = KIND_UNUSED;
    else                kind = KIND_CLEAR;
    case ($urandom_range(0, 7))
      0, 1:    cls = CLASS_W'($urandom_range(0, 255));
      2:       cls = 8'hFF - CLASS_W'($urandom_range(0, 3));
      default: cls = CLASS_W'($urandom_range(0, 7));
    endcase
    case ($urandom_range(0, 9))
      0:       value = VALUE_TOP;
      1:       value = VALUE_BOTTOM;
      2, 3:    value = VALUE_W'(int'($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
      default: value = $urandom;
    endcase
    send_item(kind, cls, value);
    ignored = (kind == KIND_UNUSED);
  endtask

  // corners: extremes, empty classes, top class, unused kind, square saturation
  task automatic test_directed_corners();
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    send_item(KIND_QUERY, 8'd0, '0);
    send_item(KIND_UPDATE, 8'd0, VALUE_TOP);
    send_item(KIND_UPDATE, 8'd0, VALUE_BOTTOM);
    send_item(KIND_UPDATE, 8'd0, '0);
    send_item(KIND_QUERY, 8'd0, '0);
    // top class must stay in its own entry
    send_item(KIND_UPDATE, 8'd255, 32'sh0001_8000);
    send_item(KIND_QUERY, 8'd255, '0);
    send_item(KIND_QUERY, 8'd254, '0);
    send_item(KIND_UNUSED, 8'd0, VALUE_TOP);
    send_item(KIND_QUERY, 8'd0, '0);
    // rising then falling samples check both min and max tracking
    send_item(KIND_UPDATE, 8'd128, 32'sh0000_0001);
    send_item(KIND_UPDATE, 8'd128, 32'sh0010_0000);
    send_item(KIND_UPDATE, 8'd128, -32'sh0010_0000);
    send_item(KIND_QUERY, 8'd128, '0);
    // square sum saturates after four bottom samples
    repeat (5) send_item(KIND_UPDATE, 8'd7, VALUE_BOTTOM);
    send_item(KIND_QUERY, 8'd7, '0);
    send_item(KIND_CLEAR, 8'd0, '0);
    send_item(KIND_QUERY, 8'd0, '0);
    send_item(KIND_QUERY, 8'd255, '0);
    // first sample after a clear starts the entry over
    send_item(KIND_UPDATE, 8'd7, -32'sh0000_0001);
    send_item(KIND_QUERY, 8'd7, '0);
  endtask

  // random mix in chunks, idling switched per chunk
  task automatic test_random_traffic(int unsigned num_items);
    int unsigned sent;
    bit          ignored;
    sent = 0;
    while (sent < num_items) begin
      if (sent % 100 == 0) begin
        src_idle_on = ($urandom_range(0, 2) != 0);
        snk_idle_on = ($urandom_range(0, 2) != 0);
      end
      send_random_item(ignored);
      if (!ignored) sent++;
    end
  endtask

  // response side held off while requests keep coming
  task automatic test_output_backpressure();
    src_idle_on = 1'b0;
    hold_rsp    = 1'b1;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 0) send_item(KIND_UPDATE, CLASS_W'(i % 4), $urandom);
      else send_item(KIND_QUERY, CLASS_W'(i % 4), '0);
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_streaming_no_idle(int unsigned num_items);
    int unsigned sent;
    bit          ignored;
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    sent = 0;
    while (sent < num_items) begin
      send_random_item(ignored);
      if (!ignored) sent++;
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    req.valid    = 1'b0;
    req.kind     = KIND_UPDATE;
    req.class_id = '0;
    req.value    = '0;
    rsp.ready    = 1'b0;
    error_count  = 0;
    quiet_cycles = 0;
    hold_rsp     = 1'b0;
    src_idle_on  = 1'b0;
    snk_idle_on  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_random_traffic(1150);
    test_output_backpressure();
    test_streaming_no_idle(250);

    // drain outstanding results
    req.valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
